// ----- hdl/kcs_pkg.sv -----
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared constants, register indexes and word types of the k-mer code scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kcs_pkg;

	localparam int MAX_K         = 32;
	localparam int K_BITS        = 6;
	localparam int CODE_BITS     = 2 * MAX_K;
	localparam int LEN_BITS      = 32;
	localparam int SEQ_BITS      = 24;
	localparam int NSEQ_BITS     = SEQ_BITS + 1;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_KMER_SIZE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SKIP      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CODE  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_CODE  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_SEQ   = 3'd4;

	localparam logic [K_BITS-1:0]    RST_KMER_SIZE = K_BITS'(MAX_K);
	localparam logic [LEN_BITS-1:0]  RST_SKIP      = LEN_BITS'(32);
	localparam logic [NSEQ_BITS-1:0] RST_NUM_SEQ   = NSEQ_BITS'(1);

	typedef struct packed {
		logic [K_BITS-1:0]    kmer_size;
		logic [LEN_BITS-1:0]  skip;
		logic [CODE_BITS-1:0] min_code;
		logic [CODE_BITS-1:0] max_code;
		logic [NSEQ_BITS-1:0] num_seq;
	} cfg_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] fwd_code;
		logic [CODE_BITS-1:0] rc_code;
		logic [LEN_BITS-1:0]  pos;
		logic [LEN_BITS-1:0]  rpos;
		logic [LEN_BITS-1:0]  len;
		logic [SEQ_BITS-1:0]  idx;
		logic                 gate;
		logic                 rev_pos_ok;
	} entry_t;

endpackage

`default_nettype wire

// ----- hdl/kcs_front.sv -----
// ----------------------------------------------------------------------------
// kcs_front
// Rolls the forward and reverse-complement codes per base and builds the word
// handed to the emission side: codes, positions and the segment gate.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_front import kcs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                accept,
	input  wire logic [1:0]          base,
	input  wire logic                first_of_segment,
	input  wire logic [LEN_BITS-1:0] segment_length,
	input  wire logic [SEQ_BITS-1:0] segment_index,
	output entry_t                   entry
);

	logic [CODE_BITS-1:0] fwd_q, rc_q;
	logic [LEN_BITS-1:0]  cnt_q, len_q;
	logic [SEQ_BITS-1:0]  idx_q;

	logic [K_BITS-1:0]    k_eff, km1, rc_sh;
	logic [CODE_BITS-1:0] mask, fwd_prev, rc_prev, fwd_n, rc_n;
	logic [LEN_BITS-1:0]  i_cur, cnt_n, len_cur, km1_ext;
	logic [SEQ_BITS-1:0]  idx_cur;

	always_comb begin
		if (cfg.kmer_size == '0) begin
			k_eff = K_BITS'(1);
		end else if (cfg.kmer_size > K_BITS'(MAX_K)) begin
			k_eff = K_BITS'(MAX_K);
		end else begin
			k_eff = cfg.kmer_size;
		end
	end

	assign km1     = k_eff - K_BITS'(1);
	assign rc_sh   = {km1[K_BITS-2:0], 1'b0};
	assign km1_ext = LEN_BITS'(km1);
	assign mask    = (k_eff >= K_BITS'(MAX_K)) ? '1
	               : ((CODE_BITS'(1) << {k_eff, 1'b0}) - CODE_BITS'(1));

	assign fwd_prev = first_of_segment ? '0 : fwd_q;
	assign rc_prev  = first_of_segment ? '0 : rc_q;
	assign i_cur    = first_of_segment ? '0 : cnt_q;
	assign len_cur  = first_of_segment ? segment_length : len_q;
	assign idx_cur  = first_of_segment ? segment_index : idx_q;

	assign fwd_n = {fwd_prev[CODE_BITS-3:0], base} & mask;
	assign rc_n  = (rc_prev >> 2) | (CODE_BITS'(base ^ 2'b11) << rc_sh);
	assign cnt_n = (i_cur == '1) ? i_cur : i_cur + LEN_BITS'(1);

	always_comb begin
		entry.fwd_code   = fwd_n;
		entry.rc_code    = rc_n;
		entry.pos        = i_cur - km1_ext;
		entry.rpos       = len_cur - i_cur - LEN_BITS'(1);
		entry.len        = len_cur;
		entry.idx        = idx_cur;
		entry.gate       = (len_cur >= cfg.skip) && (i_cur < len_cur) && (i_cur >= km1_ext);
		entry.rev_pos_ok = ({1'b0, i_cur} + (LEN_BITS+1)'(1)) >= {1'b0, cfg.skip};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rc_q  <= '0;
			cnt_q <= '0;
			len_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			fwd_q <= fwd_n;
			rc_q  <= rc_n;
			cnt_q <= cnt_n;
			len_q <= len_cur;
			idx_q <= idx_cur;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/kcs_fifo.sv -----
// ----------------------------------------------------------------------------
// kcs_fifo
// Short register queue between the rolling front and the emission back.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_fifo import kcs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_data,
	output logic        full,
	input  wire logic   rd_en,
	output logic        rd_valid,
	output entry_t      rd_data
);

	entry_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_wr, do_rd;

	assign full     = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
				          : wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
				          : rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- hdl/kcs_back.sv -----
// ----------------------------------------------------------------------------
// kcs_back
// Filters the queued codes and emits forward then reverse results through
// a one-word output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcs_back import kcs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 head_valid,
	input  wire entry_t               head,
	output logic                      head_pop,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [CODE_BITS-1:0]      code,
	output logic                      reverse_strand,
	output logic [SEQ_BITS-1:0]       seq_number,
	output logic [LEN_BITS-1:0]       rel_pos,
	output logic                      last
);

	logic                 phase_q, out_valid_q;
	logic [CODE_BITS-1:0] out_code_q;
	logic                 out_rev_q, out_last_q;
	logic [SEQ_BITS-1:0]  out_seq_q;
	logic [LEN_BITS-1:0]  out_pos_q;

	logic                 fwd_pos_ok, fwd_pass, rc_pass, fwd_ok, rev_ok;
	logic                 has_res, both, out_free, load;
	logic [SEQ_BITS-1:0]  rseq;

	assign fwd_pos_ok = ({1'b0, head.pos} + {1'b0, cfg.skip}) <= {1'b0, head.len};
	assign fwd_pass   = ((cfg.min_code == '0) || (cfg.min_code < head.fwd_code))
	                  && (head.fwd_code <= cfg.max_code);
	assign rc_pass    = ((cfg.min_code == '0) || (cfg.min_code < head.rc_code))
	                  && (head.rc_code <= cfg.max_code);
	assign fwd_ok     = head.gate && fwd_pos_ok && fwd_pass && !phase_q;
	assign rev_ok     = head.gate && head.rev_pos_ok && rc_pass;
	assign rseq       = SEQ_BITS'(cfg.num_seq - NSEQ_BITS'(1) - NSEQ_BITS'(head.idx));

	assign has_res  = fwd_ok || rev_ok;
	assign both     = fwd_ok && rev_ok;
	assign out_free = !out_valid_q || pop;
	assign load     = head_valid && out_free && has_res;
	assign head_pop = head_valid && (!has_res || (out_free && !both));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load && both) begin
				phase_q <= 1'b1;
			end else if (head_pop) begin
				phase_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_code_q <= fwd_ok ? head.fwd_code : head.rc_code;
			out_rev_q  <= !fwd_ok;
			out_seq_q  <= fwd_ok ? head.idx : rseq;
			out_pos_q  <= fwd_ok ? head.pos : head.rpos;
			out_last_q <= !both;
		end
	end

	assign empty          = !out_valid_q;
	assign code           = out_code_q;
	assign reverse_strand = out_rev_q;
	assign seq_number     = out_seq_q;
	assign rel_pos        = out_pos_q;
	assign last           = out_last_q;

	a_split_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		(load && both) |=> (phase_q && head_valid))
		else $error("head lost after forward half of a pair");

	a_phase_has_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (head_valid && rev_ok))
		else $error("pending reverse word without a passing reverse code");

	a_reverse_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rev_q) |-> out_last_q)
		else $error("reverse word not marked last");

endmodule

`default_nettype wire

// ----- hdl/kmer_code_scanner.sv -----
// ----------------------------------------------------------------------------
// kmer_code_scanner
// Rolling forward and reverse-complement k-mer codes over a base stream.
//
// Input side is a queue: drive base, first_of_segment, segment_length and
// segment_index with push; a word is taken at an edge with push high and
// full low. Result side is a queue: while empty is low the oldest result is
// on code/reverse_strand/seq_number/rel_pos/last; pop takes it.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no base or result is in flight.
// The first result of a base passes through the queue and the output register.
// Throughput: one base per cycle while pop is high and each base yields at
// most one result; when both codes pass, the base waits at the queue head
// while the single output register drains one result per cycle.
// Reset clears the rolling codes, counters and queues and loads register defaults
// (k=32, skip 32, no lower bound, full upper bound, one sequence).
// When pop stays low the output register holds its word, the two-entry
// queue behind it fills, and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_code_scanner import kcs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [1:0]               base,
	input  wire logic                     first_of_segment,
	input  wire logic [LEN_BITS-1:0]      segment_length,
	input  wire logic [SEQ_BITS-1:0]      segment_index,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [CODE_BITS-1:0]          code,
	output logic                          reverse_strand,
	output logic [SEQ_BITS-1:0]           seq_number,
	output logic [LEN_BITS-1:0]           rel_pos,
	output logic                          last,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t   cfg_q;
	entry_t front_word, head_word;
	logic   accept, head_valid, head_pop;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kmer_size <= RST_KMER_SIZE;
			cfg_q.skip      <= RST_SKIP;
			cfg_q.min_code  <= '0;
			cfg_q.max_code  <= '1;
			cfg_q.num_seq   <= RST_NUM_SEQ;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KMER_SIZE: cfg_q.kmer_size <= cfg_data[K_BITS-1:0];
				REG_SKIP:      cfg_q.skip      <= cfg_data[LEN_BITS-1:0];
				REG_MIN_CODE:  cfg_q.min_code  <= cfg_data[CODE_BITS-1:0];
				REG_MAX_CODE:  cfg_q.max_code  <= cfg_data[CODE_BITS-1:0];
				REG_NUM_SEQ:   cfg_q.num_seq   <= cfg_data[NSEQ_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	kcs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.accept           (accept),
		.base             (base),
		.first_of_segment (first_of_segment),
		.segment_length   (segment_length),
		.segment_index    (segment_index),
		.entry            (front_word)
	);

	kcs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_word),
		.full     (full),
		.rd_en    (head_pop),
		.rd_valid (head_valid),
		.rd_data  (head_word)
	);

	kcs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_valid     (head_valid),
		.head           (head_word),
		.head_pop       (head_pop),
		.empty          (empty),
		.pop            (pop),
		.code           (code),
		.reverse_strand (reverse_strand),
		.seq_number     (seq_number),
		.rel_pos        (rel_pos),
		.last           (last)
	);

endmodule

`default_nettype wire

// ----- sim/kmer_code_scanner_check.sv -----
// ----------------------------------------------------------------------------
// kmer_code_scanner_check
// Watches the base, result and register channels of the k-mer code scanner,
// rolls its own forward and reverse-complement codes for every accepted base
// and compares each popped result, field by field, with the oldest k-mer
// still owed. Reports a running mismatch count and the number of k-mers owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmer_code_scanner_check import kcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic [1:0]               base,
	input  logic                     first_of_segment,
	input  logic [LEN_BITS-1:0]      segment_length,
	input  logic [SEQ_BITS-1:0]      segment_index,
	input  logic                     empty,
	input  logic                     pop,
	input  logic [CODE_BITS-1:0]     code,
	input  logic                     reverse_strand,
	input  logic [SEQ_BITS-1:0]      seq_number,
	input  logic [LEN_BITS-1:0]      rel_pos,
	input  logic                     last,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       errors,
	output int                       pending
);

	typedef struct {
		logic [CODE_BITS-1:0] code;
		logic                 rev;
		logic [SEQ_BITS-1:0]  seq;
		logic [LEN_BITS-1:0]  pos;
		logic                 last;
	} kmer_t;

	int    fail_count = 0;
	kmer_t kmer_queue[$];

	logic [K_BITS-1:0]    k_reg;
	logic [LEN_BITS-1:0]  skip_reg;
	logic [CODE_BITS-1:0] min_reg;
	logic [CODE_BITS-1:0] max_reg;
	logic [NSEQ_BITS-1:0] nseq_reg;

	logic [CODE_BITS-1:0] fwd;
	logic [CODE_BITS-1:0] rc;
	logic [LEN_BITS-1:0]  count;
	logic [LEN_BITS-1:0]  seg_len;
	logic [SEQ_BITS-1:0]  seg_idx;

	assign errors = fail_count;

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 50) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
	endtask

	function automatic logic in_bounds(input logic [CODE_BITS-1:0] c);
		return (min_reg == '0 || min_reg < c) && c <= max_reg;
	endfunction

	task automatic scan_base(input logic [1:0] b, input logic first,
			input logic [LEN_BITS-1:0] len_in, input logic [SEQ_BITS-1:0] idx_in);
		int unsigned k;
		logic [63:0] mask;
		logic [63:0] i;
		logic [63:0] p;
		logic [63:0] rpos;
		logic [63:0] len;
		logic [63:0] skip;
		kmer_t       hit;
		kmer_t       found[$];

		k = k_reg;
		if (k < 1) k = 1;
		if (k > MAX_K) k = MAX_K;
		mask = (k >= MAX_K) ? '1 : (64'd1 << (2 * k)) - 64'd1;

		if (first) begin
			seg_len = len_in;
			seg_idx = idx_in;
			count = '0;
			fwd = '0;
			rc = '0;
		end

		fwd = ((fwd << 2) | 64'(b)) & mask;
		rc = (rc >> 2) | (64'(b ^ 2'b11) << (2 * (k - 1)));

		i = count;
		if (count != '1) count++;

		len = seg_len;
		skip = skip_reg;
		if (len < skip || i >= len || i + 64'd1 < 64'(k)) return;

		p = i + 64'd1 - 64'(k);
		if (p + skip <= len && in_bounds(fwd)) begin
			hit.code = fwd;
			hit.rev = 1'b0;
			hit.seq = seg_idx;
			hit.pos = LEN_BITS'(p);
			hit.last = 1'b0;
			found.push_back(hit);
		end
		rpos = len - 64'(k) - p;
		if (rpos + skip <= len && in_bounds(rc)) begin
			hit.code = rc;
			hit.rev = 1'b1;
			hit.seq = SEQ_BITS'(64'(nseq_reg) - 64'd1 - 64'(seg_idx));
			hit.pos = LEN_BITS'(rpos);
			hit.last = 1'b0;
			found.push_back(hit);
		end
		if (found.size() > 0) found[found.size() - 1].last = 1'b1;
		foreach (found[n]) kmer_queue.push_back(found[n]);
	endtask

	task automatic check_result();
		kmer_t want;

		if (kmer_queue.size() == 0) begin
			flag($sformatf("unexpected word code %h rev %b seq %h pos %h last %b",
				code, reverse_strand, seq_number, rel_pos, last));
			return;
		end
		want = kmer_queue.pop_front();
		if (code !== want.code)
			flag($sformatf("code got %h want %h", code, want.code));
		if (reverse_strand !== want.rev)
			flag($sformatf("reverse_strand got %b want %b", reverse_strand, want.rev));
		if (seq_number !== want.seq)
			flag($sformatf("seq_number got %h want %h", seq_number, want.seq));
		if (rel_pos !== want.pos)
			flag($sformatf("rel_pos got %h want %h", rel_pos, want.pos));
		if (last !== want.last)
			flag($sformatf("last got %b want %b", last, want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_reg = RST_KMER_SIZE;
			skip_reg = RST_SKIP;
			min_reg = '0;
			max_reg = '1;
			nseq_reg = RST_NUM_SEQ;
			fwd = '0;
			rc = '0;
			count = '0;
			seg_len = '0;
			seg_idx = '0;
			kmer_queue.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KMER_SIZE: k_reg = cfg_data[K_BITS-1:0];
					REG_SKIP:      skip_reg = cfg_data[LEN_BITS-1:0];
					REG_MIN_CODE:  min_reg = cfg_data[CODE_BITS-1:0];
					REG_MAX_CODE:  max_reg = cfg_data[CODE_BITS-1:0];
					REG_NUM_SEQ:   nseq_reg = cfg_data[NSEQ_BITS-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) check_result();
			if (push && !full)
				scan_base(base, first_of_segment, segment_length, segment_index);
			pending <= kmer_queue.size();
		end
	end

endmodule

// ----- sim/kmer_code_scanner_test.sv -----
// ----------------------------------------------------------------------------
// kmer_code_scanner_test
// Drives the k-mer code scanner with short directed segments and then with
// random segments under many register settings (extreme and out-of-range k,
// skip below k, short segments, bases past the end, code bounds, mirrored
// sequence numbers). Bases arrive in bursts, results are popped with varying
// stall rates, and a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmer_code_scanner_test import kcs_pkg::*;;

	localparam int ITEMS        = 1900;
	localparam int LIMIT        = 500000;
	localparam int DRAIN_CYCLES = 16;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic [1:0]               base = '0;
	logic                     first_of_segment = 1'b0;
	logic [LEN_BITS-1:0]      segment_length = '0;
	logic [SEQ_BITS-1:0]      segment_index = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic [CODE_BITS-1:0]     code;
	logic                     reverse_strand;
	logic [SEQ_BITS-1:0]      seq_number;
	logic [LEN_BITS-1:0]      rel_pos;
	logic                     last;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	int                       errors;
	int                       pending;

	int cycles = 0;
	int sent = 0;
	int burst_left = 0;
	int stall_pct = 0;
	int stall_left = 0;

	kmer_code_scanner i_dut (.*);

	kmer_code_scanner_check i_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycles <= cycles + 1;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		pop <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send(input logic [1:0] b, input logic f,
			input logic [LEN_BITS-1:0] len, input logic [SEQ_BITS-1:0] idx);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			case ($urandom_range(0, 9))
				0: burst_left = $urandom_range(60, 120);
				1, 2, 3, 4: burst_left = $urandom_range(8, 30);
				default: burst_left = $urandom_range(1, 8);
			endcase
		end
		push <= 1'b1;
		base <= b;
		first_of_segment <= f;
		segment_length <= len;
		segment_index <= idx;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_segment(input logic [LEN_BITS-1:0] len, input int nbases);
		send(2'($urandom), 1'b1, len, SEQ_BITS'($urandom));
		repeat (nbases - 1) send(2'($urandom), 1'b0, $urandom, SEQ_BITS'($urandom));
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input logic [K_BITS-1:0] k, input logic [LEN_BITS-1:0] skip,
			input logic [CODE_BITS-1:0] lo, input logic [CODE_BITS-1:0] hi,
			input logic [NSEQ_BITS-1:0] nseq);
		settle();
		write_reg(REG_KMER_SIZE, {$urandom, 26'($urandom), k});
		write_reg(REG_SKIP, {$urandom, skip});
		write_reg(REG_MIN_CODE, lo);
		write_reg(REG_MAX_CODE, hi);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_BITS'(REG_NUM_SEQ + $urandom_range(1, 3)), {$urandom, $urandom});
		write_reg(REG_NUM_SEQ, {$urandom, 7'($urandom), nseq});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned          kw;
		int unsigned          keff;
		int                   nb;
		logic [LEN_BITS-1:0]  skip;
		logic [LEN_BITS-1:0]  len;
		logic [CODE_BITS-1:0] span;
		logic [CODE_BITS-1:0] lo;
		logic [CODE_BITS-1:0] hi;
		logic [CODE_BITS-1:0] a;
		logic [CODE_BITS-1:0] b;
		logic [NSEQ_BITS-1:0] nseq;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// bases before any segment start, reset settings
		send(2'd1, 1'b0, '1, '1);
		send(2'd2, 1'b0, '0, '0);

		// k of zero acts as one; sequence count zero wraps the mirrored number
		configure('0, 1, '0, '1, '0);
		send(2'd0, 1'b1, 4, '0);
		send(2'd1, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd2, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd3, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd3, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd2, 1'b1, '0, SEQ_BITS'($urandom));
		send(2'd3, 1'b1, '1, '1);
		send(2'd0, 1'b0, $urandom, SEQ_BITS'($urandom));

		// skip below k with both code bounds active
		configure(K_BITS'(2), 1, CODE_BITS'(1), CODE_BITS'(14), NSEQ_BITS'(1) << SEQ_BITS);
		send(2'd0, 1'b1, 5, 5);
		send(2'd0, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd1, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd3, 1'b0, $urandom, SEQ_BITS'($urandom));
		send(2'd3, 1'b0, $urandom, SEQ_BITS'($urandom));

		// segment shorter than skip
		configure(K_BITS'(3), 6, '0, '1, NSEQ_BITS'(3));
		send_segment(5, 5);

		while (sent < ITEMS) begin
			case ($urandom_range(0, 9))
				0: kw = 0;
				1: kw = 1;
				2: kw = $urandom_range(2, 4);
				7: kw = MAX_K;
				8: kw = $urandom_range(MAX_K + 1, (1 << K_BITS) - 1);
				default: kw = $urandom_range(1, MAX_K);
			endcase
			keff = (kw < 1) ? 1 : ((kw > MAX_K) ? MAX_K : kw);

			case ($urandom_range(0, 9))
				0: skip = $urandom_range(1, keff);
				1: skip = '1;
				default: skip = keff + $urandom_range(0, 6);
			endcase

			span = (keff >= MAX_K) ? '1 : (64'd1 << (2 * keff)) - 64'd1;
			lo = '0;
			hi = '1;
			if ($urandom_range(0, 9) >= 6) begin
				a = {$urandom, $urandom} & span;
				b = {$urandom, $urandom} & span;
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
				if ($urandom_range(0, 3) == 0) lo = '0;
				if ($urandom_range(0, 3) == 0) hi = '1;
			end

			case ($urandom_range(0, 4))
				0: nseq = '0;
				1: nseq = NSEQ_BITS'(1) << SEQ_BITS;
				2: nseq = NSEQ_BITS'($urandom);
				default: nseq = NSEQ_BITS'($urandom_range(1, 16));
			endcase

			configure(K_BITS'(kw), skip, lo, hi, nseq);

			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 19))
					0: begin
						len = '0;
						nb = $urandom_range(1, 3);
					end
					1: begin
						len = '1;
						nb = keff + $urandom_range(0, 8);
					end
					2: begin
						len = $urandom;
						nb = keff + $urandom_range(0, 8);
					end
					3, 4: begin
						len = $urandom_range(1, keff);
						nb = len;
					end
					default: begin
						len = keff + $urandom_range(0, 12);
						nb = len;
					end
				endcase
				case ($urandom_range(0, 9))
					0: nb = nb + $urandom_range(1, 4);
					1: nb = $urandom_range(1, nb);
					default: ;
				endcase
				send_segment(len, nb);
			end
		end

		settle();
		if (errors == 0) begin
			$display("kmer_code_scanner_test passed");
		end else begin
			$display("kmer_code_scanner_test failed");
		end
		$finish;
	end

	initial begin
		while (cycles < LIMIT) @(posedge clk);
		$display("kmer_code_scanner_test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/kcs_pkg.sv
hdl/kcs_front.sv
hdl/kcs_fifo.sv
hdl/kcs_back.sv
hdl/kmer_code_scanner.sv
sim/kmer_code_scanner_check.sv
sim/kmer_code_scanner_test.sv
